// File: rtl/core/sacl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared constants, types and helpers for the LRU cache tag model.
// ----------------------------------------------------------------------------
package sacl_pkg;

   localparam int unsigned MAX_SETS_DEF   = 256;
   localparam int unsigned MAX_WAYS_DEF   = 8;
   localparam int unsigned ADDR_WIDTH_DEF = 64;

   localparam int unsigned CFG_WIDTH   = 6;
   localparam int unsigned CNT_WIDTH   = 32;
   localparam int unsigned OP_WIDTH    = 2;
   localparam int unsigned CSR_IDX_W   = 2;

   typedef enum logic [1:0] {
      OP_IFETCH = 2'd0,
      OP_LOAD   = 2'd1,
      OP_STORE  = 2'd2,
      OP_MODIFY = 2'd3
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS     = 2'd2;

   function automatic logic [CNT_WIDTH-1:0] sat_inc(input logic [CNT_WIDTH-1:0] v);
      sat_inc = (v == {CNT_WIDTH{1'b1}}) ? v : v + 1'b1;
   endfunction

endpackage : sacl_pkg
`default_nettype wire

// File: rtl/core/sacl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sacl_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : sacl_ram
`default_nettype wire

// File: rtl/core/sacl_way_logic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_way_logic
// Per-set lookup: tag compare, LRU age update and victim choice.
// ----------------------------------------------------------------------------
module sacl_way_logic #(
   parameter int unsigned MAX_WAYS  = 8,
   parameter int unsigned TAG_WIDTH = 62,
   parameter int unsigned AGE_WIDTH = 3
) (
   input  wire logic [MAX_WAYS-1:0]                valid_i,
   input  wire logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] tag_i,
   input  wire logic [MAX_WAYS-1:0][AGE_WIDTH-1:0] age_i,
   input  wire logic [TAG_WIDTH-1:0]               look_tag,
   input  wire logic [$clog2(MAX_WAYS+1)-1:0]      ways_used,
   output      logic [MAX_WAYS-1:0]                valid_o,
   output      logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] tag_o,
   output      logic [MAX_WAYS-1:0][AGE_WIDTH-1:0] age_o,
   output      logic                               hit,
   output      logic                               evicted
);

   localparam logic [AGE_WIDTH-1:0] AGE_MAX = AGE_WIDTH'(MAX_WAYS - 1);

   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] match;
   logic [MAX_WAYS-1:0] hit_sel;
   logic [MAX_WAYS-1:0] free_sel;
   logic [MAX_WAYS-1:0] old_sel;
   logic [AGE_WIDTH-1:0] ref_age;
   logic [AGE_WIDTH-1:0] max_age;
   logic                 found;
   logic                 free_found;
   logic                 old_found;

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w] = (w < int'(ways_used));
         match[w]  = in_use[w] && valid_i[w] && (tag_i[w] == look_tag);
      end
      // first match, first free way, greatest age (lowest way on a tie)
      found = 1'b0; free_found = 1'b0;
      hit_sel = '0; free_sel = '0;
      ref_age = '0; max_age = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (match[w] && !found) begin
            found = 1'b1; hit_sel[w] = 1'b1; ref_age = age_i[w];
         end
         if (in_use[w] && !valid_i[w] && !free_found) begin
            free_found = 1'b1; free_sel[w] = 1'b1;
         end
         if (in_use[w] && age_i[w] > max_age) begin
            max_age = age_i[w];
         end
      end
      old_found = 1'b0; old_sel = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (in_use[w] && age_i[w] == max_age && !old_found) begin
            old_found = 1'b1; old_sel[w] = 1'b1;
         end
      end
      hit     = found;
      evicted = !found && !free_found;

      valid_o = valid_i;
      tag_o   = tag_i;
      age_o   = age_i;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (in_use[w]) begin
            if (found) begin
               if (hit_sel[w]) begin
                  age_o[w] = '0;
               end else if (valid_i[w] && age_i[w] < ref_age && age_i[w] < AGE_MAX) begin
                  age_o[w] = age_i[w] + 1'b1;
               end
            end else if (free_found) begin
               if (free_sel[w]) begin
                  valid_o[w] = 1'b1; tag_o[w] = look_tag; age_o[w] = '0;
               end else if (valid_i[w] && age_i[w] < AGE_MAX) begin
                  age_o[w] = age_i[w] + 1'b1;
               end
            end else begin
               if (old_sel[w]) begin
                  tag_o[w] = look_tag; age_o[w] = '0;
               end else if (age_i[w] < AGE_MAX) begin
                  age_o[w] = age_i[w] + 1'b1;
               end
            end
         end
      end
   end

endmodule : sacl_way_logic
`default_nettype wire

// File: rtl/core/set_assoc_cache_lru_sim_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_top
// Tag and LRU model of a set-associative cache driven by trace records.
// ----------------------------------------------------------------------------
// channel | dir | ports                              | word
// req     | in  | req_valid/req_stall                | operation, address
// rsp     | out | rsp_valid/rsp_stall                | hit, evicted, last, totals
// csr     | in  | csr_write_en/csr_index/csr_data    | one register
//
// A lookup reads the set from the memories (ST_READ), then updates it and
// writes it back (ST_UPDATE). A load/store makes one lookup, a modify two; a
// fetch is taken in ST_IDLE with no lookup and no result word.
// After reset a clearing pass runs over all MAX_SETS sets (valid and age zeroed),
// during which no record is taken. A held result blocks the next lookup only
// when it would have to be replaced.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_top #(
   parameter int unsigned MAX_SETS   = sacl_pkg::MAX_SETS_DEF,
   parameter int unsigned MAX_WAYS   = sacl_pkg::MAX_WAYS_DEF,
   parameter int unsigned ADDR_WIDTH = sacl_pkg::ADDR_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic [sacl_pkg::OP_WIDTH-1:0]     req_operation,
   input  wire logic [ADDR_WIDTH-1:0]             req_address,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic                              rsp_hit,
   output      logic                              rsp_evicted,
   output      logic                              rsp_last,
   output      logic [sacl_pkg::CNT_WIDTH-1:0]    rsp_hit_total,
   output      logic [sacl_pkg::CNT_WIDTH-1:0]    rsp_miss_total,
   output      logic [sacl_pkg::CNT_WIDTH-1:0]    rsp_eviction_total,
   input  wire logic                              csr_write_en,
   input  wire logic [sacl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sacl_pkg::CFG_WIDTH-1:0]    csr_data
);

   localparam int unsigned SET_W  = $clog2(MAX_SETS);
   localparam int unsigned KMAX   = $clog2(MAX_SETS + 1) - 1;  // largest k, 2^k <= MAX_SETS
   localparam int unsigned TAG_W  = ADDR_WIDTH - 2;
   localparam int unsigned AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int unsigned WAYC_W = $clog2(MAX_WAYS + 1);
   localparam int unsigned SB_W   = $clog2(KMAX + 1);
   localparam int unsigned VA_W   = MAX_WAYS * (1 + AGE_W);
   localparam int unsigned TG_W   = MAX_WAYS * TAG_W;

   typedef enum logic [1:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_UPDATE
   } state_type;

   state_type state_ff;
   logic [SET_W-1:0] clr_ff;
   logic [3:0] set_bits_ff;
   logic [5:0] off_bits_ff;
   logic [3:0] ways_ff;
   logic       second_ff;   // more lookups pending for this record
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic [SET_W-1:0] set_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [sacl_pkg::CNT_WIDTH-1:0] hits_ff, miss_ff, evs_ff;
   logic rsp_valid_ff, rsp_hit_ff, rsp_ev_ff, rsp_last_ff;

   // effective configuration
   logic [SB_W-1:0]   s_eff;
   logic [5:0]        b_eff;
   logic [WAYC_W-1:0] e_eff;
   always_comb begin
      if (set_bits_ff == 4'd0) s_eff = SB_W'(1);
      else if (32'(set_bits_ff) > KMAX) s_eff = SB_W'(KMAX);
      else s_eff = SB_W'(set_bits_ff);
      if (off_bits_ff == 6'd0) b_eff = 6'd1;
      else if (off_bits_ff > 6'd32) b_eff = 6'd32;
      else b_eff = off_bits_ff;
      if (ways_ff == 4'd0) e_eff = WAYC_W'(1);
      else if (32'(ways_ff) > MAX_WAYS) e_eff = WAYC_W'(MAX_WAYS);
      else e_eff = WAYC_W'(ways_ff);
   end

   // address split of the latched address
   logic [ADDR_WIDTH-1:0] a_shift;
   logic [ADDR_WIDTH-1:0] t_shift;
   logic [SET_W-1:0]      look_set;
   logic [TAG_W-1:0]      look_tag;
   always_comb begin
      a_shift  = addr_ff >> b_eff;
      t_shift  = a_shift >> s_eff;
      look_set = a_shift[SET_W-1:0] & SET_W'((1 << s_eff) - 1);
      look_tag = t_shift[TAG_W-1:0];
   end

   // memories: valid+age per set, tags per set
   logic             va_we, tg_we;
   logic [SET_W-1:0] va_waddr, rd_addr;
   logic [VA_W-1:0]  va_wdata, va_rdata;
   logic [TG_W-1:0]  tg_wdata, tg_rdata;

   sacl_ram #(.WIDTH(VA_W), .DEPTH(MAX_SETS)) u_va_ram (
      .clock, .wr_en(va_we), .wr_addr(va_waddr), .wr_data(va_wdata),
      .rd_addr(rd_addr), .rd_data(va_rdata));
   sacl_ram #(.WIDTH(TG_W), .DEPTH(MAX_SETS)) u_tag_ram (
      .clock, .wr_en(tg_we), .wr_addr(set_ff), .wr_data(tg_wdata),
      .rd_addr(rd_addr), .rd_data(tg_rdata));

   logic [MAX_WAYS-1:0]            v_in, v_out;
   logic [MAX_WAYS-1:0][AGE_W-1:0] a_in, a_out;
   logic [MAX_WAYS-1:0][TAG_W-1:0] t_in, t_out;
   logic look_hit, look_ev;

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         v_in[w] = va_rdata[w*(1+AGE_W)];
         a_in[w] = va_rdata[w*(1+AGE_W)+1 +: AGE_W];
         t_in[w] = tg_rdata[w*TAG_W +: TAG_W];
         va_wdata[w*(1+AGE_W)] = v_out[w];
         va_wdata[w*(1+AGE_W)+1 +: AGE_W] = a_out[w];
         tg_wdata[w*TAG_W +: TAG_W] = t_out[w];
      end
      // clearing pass writes invalid lines of age zero
      if (state_ff == ST_CLEAR) begin
         va_wdata = '0;
      end
   end

   sacl_way_logic #(.MAX_WAYS(MAX_WAYS), .TAG_WIDTH(TAG_W), .AGE_WIDTH(AGE_W)) u_way (
      .valid_i(v_in), .tag_i(t_in), .age_i(a_in), .look_tag(tag_ff), .ways_used(e_eff),
      .valid_o(v_out), .tag_o(t_out), .age_o(a_out), .hit(look_hit), .evicted(look_ev));

   logic rsp_free;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rd_addr   = look_set;
   assign va_we     = (state_ff == ST_CLEAR) || (state_ff == ST_UPDATE && rsp_free);
   assign tg_we     = (state_ff == ST_UPDATE) && rsp_free;
   assign va_waddr  = (state_ff == ST_CLEAR) ? clr_ff : set_ff;

   // after a write-back the next lookup of a modify re-reads the same set; the
   // ST_READ state lets the registered read see the written data, so no bypass needed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         set_bits_ff  <= 4'd1;
         off_bits_ff  <= 6'd1;
         ways_ff      <= 4'd1;
         second_ff    <= 1'b0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         evs_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               sacl_pkg::CSR_SET_BITS: set_bits_ff <= csr_data[3:0];
               sacl_pkg::CSR_OFF_BITS: off_bits_ff <= csr_data;
               sacl_pkg::CSR_WAYS:     ways_ff     <= csr_data[3:0];
               default: ;
            endcase
         end
         // in ST_UPDATE the word register is handled by the update itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_UPDATE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == SET_W'(MAX_SETS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  addr_ff   <= req_address;
                  second_ff <= (req_operation == sacl_pkg::OP_MODIFY);
                  if (req_operation != sacl_pkg::OP_IFETCH) begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               set_ff   <= look_set;
               tag_ff   <= look_tag;
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= look_hit;
                  rsp_ev_ff    <= look_ev;
                  rsp_last_ff  <= !second_ff;
                  if (look_hit) begin
                     hits_ff <= sacl_pkg::sat_inc(hits_ff);
                  end else begin
                     miss_ff <= sacl_pkg::sat_inc(miss_ff);
                  end
                  if (look_ev) begin
                     evs_ff <= sacl_pkg::sat_inc(evs_ff);
                  end
                  second_ff <= 1'b0;
                  state_ff  <= second_ff ? ST_READ : ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // totals: counters already include the current word's lookup
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_evicted        = rsp_ev_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_hit_total      = hits_ff;
   assign rsp_miss_total     = miss_ff;
   assign rsp_eviction_total = evs_ff;

endmodule : set_assoc_cache_lru_sim_top
`default_nettype wire
